// ----- rtl/tkts_pkg.sv -----
`timescale 1ns / 1ps

package tkts_pkg;

   localparam int K_MAX     = 64;
   localparam int SLOT_W    = $clog2(K_MAX);
   localparam int K_W       = 7;
   localparam int VOCAB_MAX = 65536;
   localparam int CNT_W     = 17;
   localparam int LOGIT_W   = 16;
   localparam int IDX_W     = 16;
   localparam int RND_W     = 16;
   localparam int STEP_W    = $clog2(RND_W);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_MODGO = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_READ  = 6'b010000,
      ST_OUT   = 6'b100000
   } tkts_state_type;

   typedef struct packed {
      logic accept;
      logic mod_start;
      logic sel_read;
      logic out_load;
   } tkts_cmd_type;

   typedef struct packed {
      logic item_last;
      logic will_replace;
      logic k_zero;
      logic last_pend;
      logic scan_done;
      logic mod_done;
      logic rsp_free;
   } tkts_sts_type;

endpackage

// ----- rtl/top_k_token_selector_top.sv -----
`timescale 1ns / 1ps

// Streaming top-k token picker. Logits (signed Q8.8) arrive one per transaction in
// vocabulary order; the transaction with req_last_item set returns one token index on
// the rsp channel. With csr_top_k_count zero the index of the first maximum is given,
// otherwise the k best logits (k capped at 64 and at the stream length) are kept and
// the slot random_word mod k is returned. An item that does not displace a kept logit
// is taken without a stall; one that does stalls the input while the minimum is
// rescanned, one slot per cycle, through the slot memory read port. A last item with k
// above zero also passes through the bit-serial remainder unit (16 steps) and the slot
// index read. A pending result waits in an output register, so the next stream may
// start while it is not yet taken. csr_top_k_count must be written only between streams;
// the block does not enforce it. Slots never filled in this stream hold stale data.
module top_k_token_selector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tkts_pkg::LOGIT_W-1:0] req_logit_value,
   input  logic                                req_last_item,
   input  logic [tkts_pkg::RND_W-1:0]          req_random_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tkts_pkg::IDX_W-1:0]          rsp_token_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tkts_pkg::K_W-1:0]            csr_top_k_count
);
   import tkts_pkg::*;

   logic [K_W-1:0] top_k_count_ff, top_k_count_in;
   tkts_cmd_type   cmd;
   tkts_sts_type   sts;

   assign csr_ready      = 1'b1;
   assign top_k_count_in = (csr_valid && csr_ready) ? csr_top_k_count : top_k_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_k_count_ff <= '0;
      end else begin
         top_k_count_ff <= top_k_count_in;
      end
   end

   tkts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tkts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .top_k_count     (top_k_count_ff),
      .req_logit_value (req_logit_value),
      .req_last_item   (req_last_item),
      .req_random_word (req_random_word),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_token_index (rsp_token_index),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ----- rtl/tkts_mod.sv -----
`timescale 1ns / 1ps

module tkts_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tkts_pkg::RND_W-1:0]    dividend,
   input  logic [tkts_pkg::K_W-1:0]      divisor,
   output logic                          done,
   output logic [tkts_pkg::SLOT_W-1:0]   remainder
);
   import tkts_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RND_W-1:0]    shift_ff, shift_in;
   logic [K_W-1:0]      div_ff, div_in;
   logic [K_W-1:0]      rem_ff, rem_in;
   logic [K_W-1:0]      trial;

   // one remainder bit per cycle, restoring form
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff[K_W-2:0], shift_ff[RND_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[RND_W-2:0], 1'b0};
         rem_in   = (trial >= div_ff) ? K_W'(trial - div_ff) : trial;
         step_in  = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

endmodule

// ----- rtl/tkts_datapath.sv -----
`timescale 1ns / 1ps

module tkts_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tkts_pkg::K_W-1:0]            top_k_count,
   input  logic signed [tkts_pkg::LOGIT_W-1:0] req_logit_value,
   input  logic                                req_last_item,
   input  logic [tkts_pkg::RND_W-1:0]          req_random_word,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [tkts_pkg::IDX_W-1:0]          rsp_token_index,
   input  tkts_pkg::tkts_cmd_type              cmd,
   output tkts_pkg::tkts_sts_type              sts
);
   import tkts_pkg::*;

   logic signed [LOGIT_W-1:0] slot_value_mem [K_MAX];
   logic [IDX_W-1:0]          slot_index_mem [K_MAX];

   logic [CNT_W-1:0]          item_count_ff, item_count_in;
   logic signed [LOGIT_W-1:0] best_value_ff, best_value_in;
   logic [IDX_W-1:0]          best_index_ff, best_index_in;
   logic signed [LOGIT_W-1:0] min_value_ff, min_value_in;
   logic [SLOT_W-1:0]         min_slot_ff, min_slot_in;
   logic                      last_pend_ff, last_pend_in;
   logic [RND_W-1:0]          rnd_ff, rnd_in;
   logic                      scan_run_ff, scan_run_in;
   logic [SLOT_W-1:0]         scan_addr_ff, scan_addr_in;
   logic                      scan_vld_ff, scan_vld_in;
   logic [SLOT_W-1:0]         scan_tag_ff, scan_tag_in;
   logic signed [LOGIT_W-1:0] scan_value_ff;
   logic [IDX_W-1:0]          sel_idx_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_token_ff, rsp_token_in;

   logic [K_W-1:0]            k_eff;
   logic [SLOT_W-1:0]         k_m1;
   logic                      idx_ok;
   logic                      idx_zero;
   logic                      fill;
   logic                      replace;
   logic [SLOT_W-1:0]         repl_slot;
   logic                      wr_en;
   logic [SLOT_W-1:0]         wr_addr;
   logic [K_W-1:0]            n_raw;
   logic [K_W-1:0]            mod_div;
   logic                      mod_done;
   logic [SLOT_W-1:0]         mod_rem;

   assign k_eff     = (top_k_count > K_W'(K_MAX)) ? K_W'(K_MAX) : top_k_count;
   assign k_m1      = SLOT_W'(k_eff - 1'b1);
   assign idx_ok    = item_count_ff < CNT_W'(VOCAB_MAX);
   assign idx_zero  = item_count_ff == '0;
   assign fill      = (k_eff != '0) && (item_count_ff < CNT_W'(k_eff));
   assign replace   = idx_ok && (k_eff != '0) && !fill && (req_logit_value > min_value_ff);
   assign repl_slot = (K_W'(min_slot_ff) < k_eff) ? min_slot_ff : '0;
   assign wr_en     = cmd.accept && idx_ok && (fill || replace);
   assign wr_addr   = fill ? item_count_ff[SLOT_W-1:0] : repl_slot;

   // slot count at the end of a stream: k capped at the item count
   assign n_raw   = (item_count_ff < CNT_W'(k_eff)) ? item_count_ff[K_W-1:0] : k_eff;
   assign mod_div = (n_raw == '0) ? K_W'(1) : n_raw;

   tkts_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (rnd_ff),
      .divisor   (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      item_count_in = item_count_ff;
      best_value_in = best_value_ff;
      best_index_in = best_index_ff;
      min_value_in  = min_value_ff;
      min_slot_in   = min_slot_ff;
      last_pend_in  = last_pend_ff;
      rnd_in        = rnd_ff;
      scan_run_in   = scan_run_ff;
      scan_addr_in  = scan_addr_ff;
      scan_vld_in   = 1'b0;
      scan_tag_in   = scan_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_token_in  = rsp_token_ff;

      if (cmd.accept) begin
         last_pend_in = req_last_item;
         rnd_in       = req_random_word;
         if (idx_ok) begin
            if (idx_zero || (req_logit_value > best_value_ff)) begin
               best_value_in = req_logit_value;
               best_index_in = item_count_ff[IDX_W-1:0];
            end
            if (fill && (idx_zero || (req_logit_value < min_value_ff))) begin
               min_value_in = req_logit_value;
               min_slot_in  = item_count_ff[SLOT_W-1:0];
            end
            if (replace) begin
               scan_run_in  = 1'b1;
               scan_addr_in = '0;
            end
            item_count_in = CNT_W'(item_count_ff + 1'b1);
         end
      end

      // minimum rescan, one slot read per cycle
      if (scan_run_ff) begin
         scan_vld_in  = 1'b1;
         scan_tag_in  = scan_addr_ff;
         scan_addr_in = SLOT_W'(scan_addr_ff + 1'b1);
         if (scan_addr_ff == k_m1) begin
            scan_run_in = 1'b0;
         end
      end
      if (scan_vld_ff) begin
         if (scan_tag_ff == '0) begin
            min_value_in = scan_value_ff;
            min_slot_in  = '0;
         end else if (scan_value_ff < min_value_ff) begin
            min_value_in = scan_value_ff;
            min_slot_in  = scan_tag_ff;
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_token_in  = (k_eff == '0) ? best_index_ff : sel_idx_ff;
         item_count_in = '0;
         best_value_in = '0;
         best_index_in = '0;
         min_value_in  = '0;
         min_slot_in   = '0;
         last_pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         best_value_ff <= '0;
         best_index_ff <= '0;
         min_value_ff  <= '0;
         min_slot_ff   <= '0;
         last_pend_ff  <= 1'b0;
         scan_run_ff   <= 1'b0;
         scan_addr_ff  <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_count_ff <= item_count_in;
         best_value_ff <= best_value_in;
         best_index_ff <= best_index_in;
         min_value_ff  <= min_value_in;
         min_slot_ff   <= min_slot_in;
         last_pend_ff  <= last_pend_in;
         scan_run_ff   <= scan_run_in;
         scan_addr_ff  <= scan_addr_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff       <= rnd_in;
      scan_tag_ff  <= scan_tag_in;
      rsp_token_ff <= rsp_token_in;
   end

   // slot stores
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_value_mem[wr_addr] <= req_logit_value;
         slot_index_mem[wr_addr] <= item_count_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (scan_run_ff) begin
         scan_value_ff <= slot_value_mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sel_read) begin
         sel_idx_ff <= slot_index_mem[mod_rem];
      end
   end

   assign sts.item_last    = req_last_item;
   assign sts.will_replace = replace;
   assign sts.k_zero       = k_eff == '0;
   assign sts.last_pend    = last_pend_ff;
   assign sts.scan_done    = scan_vld_ff && (scan_tag_ff == k_m1);
   assign sts.mod_done     = mod_done;
   assign sts.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_index = rsp_token_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CNT_W'(VOCAB_MAX))
      else $error("item count beyond vocabulary limit");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      (scan_run_ff || scan_vld_ff) |-> !cmd.accept)
      else $error("transaction taken during rescan");

endmodule

// ----- rtl/tkts_ctrl.sv -----
`timescale 1ns / 1ps

module tkts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tkts_pkg::tkts_sts_type sts,
   output tkts_pkg::tkts_cmd_type cmd
);
   import tkts_pkg::*;

   tkts_state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.mod_start = 1'b0;
      cmd.sel_read  = 1'b0;
      cmd.out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.will_replace) begin
                  state_in = ST_SCAN;
               end else if (sts.item_last) begin
                  state_in = sts.k_zero ? ST_OUT : ST_MODGO;
               end
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = sts.last_pend ? ST_MODGO : ST_IDLE;
            end
         end
         ST_MODGO: begin
            cmd.mod_start = 1'b1;
            state_in      = ST_MOD;
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.sel_read = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !sts.rsp_free |=> (state_ff == ST_OUT))
      else $error("result dropped while output busy");

endmodule

// ----- bench/tb_top_k_token_selector_top.sv -----
`timescale 1ns / 1ps

module tb_top_k_token_selector_top;
   import tkts_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS  = 1150;

   typedef enum int {SHAPE_RANDOM, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING} shape_type;

   typedef struct {
      logic signed [LOGIT_W-1:0] value;
      logic                      last;
      logic [RND_W-1:0]          rnd;
   } logit_item_type;

   class token_scoreboard;
      logic [K_W-1:0]            top_k;
      logic [IDX_W-1:0]          kept_index[K_MAX];
      logic signed [LOGIT_W-1:0] kept_value[K_MAX];
      int unsigned               low_slot;
      logic signed [LOGIT_W-1:0] low_value;
      int unsigned               seen;
      logic signed [LOGIT_W-1:0] peak_value;
      int unsigned               peak_index;
      logic [IDX_W-1:0]          token_queue[$];
      int                        mismatch_count;

      function new();
         top_k = '0;
         foreach (kept_index[i]) begin
            kept_index[i] = '0;
            kept_value[i] = '0;
         end
         mismatch_count = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         low_slot   = 0;
         low_value  = '0;
         seen       = 0;
         peak_value = '0;
         peak_index = 0;
      endfunction

      function void set_k(logic [K_W-1:0] value);
         top_k = value;
      endfunction

      function void note_logit(logic signed [LOGIT_W-1:0] v, logic last,
                               logic [RND_W-1:0] rnd);
         int unsigned k;
         int unsigned n;
         int unsigned s;
         k = (top_k > K_MAX) ? K_MAX : top_k;
         if (seen < VOCAB_MAX) begin
            if (seen == 0 || v > peak_value) begin
               peak_value = v;
               peak_index = seen;
            end
            if (k > 0) begin
               if (seen < k) begin
                  kept_index[seen] = IDX_W'(seen);
                  kept_value[seen] = v;
                  if (seen == 0 || v < low_value) begin
                     low_value = v;
                     low_slot  = seen;
                  end
               end else if (v > low_value) begin
                  s = (low_slot < k) ? low_slot : 0;
                  kept_index[s] = IDX_W'(seen);
                  kept_value[s] = v;
                  // rescan the minimum, lowest slot wins a tie
                  low_slot  = 0;
                  low_value = kept_value[0];
                  for (int j = 1; j < k; j++) begin
                     if (kept_value[j] < low_value) begin
                        low_value = kept_value[j];
                        low_slot  = j;
                     end
                  end
               end
            end
            seen++;
         end
         if (last) begin
            if (k == 0) begin
               token_queue.push_back(IDX_W'(peak_index));
            end else begin
               n = (k < seen) ? k : seen;
               if (n == 0) n = 1;
               token_queue.push_back(kept_index[rnd % n]);
            end
            clear_stream();
         end
      endfunction

      task report(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
         mismatch_count++;
         $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
      endtask

      task check_token(logic [IDX_W-1:0] got);
         logic [IDX_W-1:0] want;
         if (token_queue.size() == 0) begin
            report("token with none expected", got, '0);
         end else begin
            want = token_queue.pop_front();
            if (got !== want) report("token_index", got, want);
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [LOGIT_W-1:0]  req_logit_value;
   logic                       req_last_item;
   logic [RND_W-1:0]           req_random_word;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [IDX_W-1:0]           rsp_token_index;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [K_W-1:0]             csr_top_k_count;

   token_scoreboard sb = new();
   logit_item_type  logit_queue[$];
   bit              quiet = 1'b0;
   bit              long_hold = 1'b0;
   int              cycle_count = 0;

   top_k_token_selector_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_logit_value (req_logit_value),
      .req_last_item   (req_last_item),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_index (rsp_token_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_top_k_count (csr_top_k_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side stall bursts
   initial begin
      int stall_left;
      bit hold;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            hold = 1'b1;
         end else if (long_hold) begin
            stall_left = HOLD_CYCLES - 1;
            long_hold  = 1'b0;
            hold       = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            hold       = 1'b1;
         end else begin
            hold = 1'b0;
         end
         rsp_stall <= hold;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_token(rsp_token_index);
   end

   task add_item(input int value, input bit last, input int rnd);
      logit_item_type item;
      item.value = LOGIT_W'(value);
      item.last  = last;
      item.rnd   = RND_W'(rnd);
      logit_queue.push_back(item);
   endtask

   task add_stream(input int len);
      shape_type shape;
      int        base;
      int        value;
      shape = shape_type'($urandom_range(0, 3));
      base  = (shape == SHAPE_RISING) ? -int'($urandom_range(0, 32768))
                                      : int'($urandom_range(0, 32767));
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_RANDOM:  value = int'($urandom_range(0, 65535)) - 32768;
            SHAPE_NARROW:  value = int'($urandom_range(0, 8)) - 4;
            SHAPE_RISING:  value = base + i;
            default:       value = base - i;
         endcase
         add_item(value, i == len - 1, $urandom_range(0, 65535));
      end
   endtask

   // entered and left at a falling edge
   task drive_items();
      logit_item_type item;
      int             gap;
      while (logit_queue.size() > 0) begin
         item = logit_queue.pop_front();
         gap  = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid       <= 1'b1;
         req_logit_value <= item.value;
         req_last_item   <= item.last;
         req_random_word <= item.rnd;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         sb.note_logit(item.value, item.last, item.rnd);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task wait_for_tokens();
      while (sb.token_queue.size() != 0) @(posedge clock);
   endtask

   task write_k(input int value);
      wait_for_tokens();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_top_k_count <= K_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_k(K_W'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int pick_k();
      case ($urandom_range(0, 9))
         0, 1:    return 0;
         2, 3, 4: return $urandom_range(1, 8);
         5, 6, 7: return $urandom_range(9, 64);
         8:       return K_MAX;
         default: return $urandom_range(65, 127);
      endcase
   endfunction

   initial begin
      int  random_items;
      int  streams;
      bit  pressure_done;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_logit_value = '0;
      req_last_item   = 1'b0;
      req_random_word = '0;
      csr_valid       = 1'b0;
      csr_top_k_count = '0;
      random_items    = 0;
      pressure_done   = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // greedy, first maximum wins
      write_k(0);
      add_item(-32768, 0, 0);
      add_item(32767, 0, 65535);
      add_item(32767, 0, 0);
      add_item(0, 1, 0);
      drive_items();

      // k above the slot count, stream shorter than k
      write_k(127);
      add_item(5, 0, 0);
      add_item(-32768, 0, 0);
      add_item(32767, 1, 65535);
      drive_items();

      // equal value does not displace
      write_k(1);
      add_item(1, 0, 0);
      add_item(1, 0, 0);
      add_item(2, 0, 0);
      add_item(1, 1, 16'hAAAA);
      drive_items();

      // single item stream
      write_k(2);
      add_item(32767, 1, 16'h5555);
      drive_items();

      write_k(65);
      add_item(-1, 0, 0);
      add_item(-1, 0, 0);
      add_item(-2, 0, 0);
      add_item(3, 0, 0);
      add_item(-32768, 1, 3);
      drive_items();

      // tied minimum, lowest slot replaced
      write_k(3);
      add_item(4, 0, 0);
      add_item(2, 0, 0);
      add_item(2, 0, 0);
      add_item(9, 0, 0);
      add_item(2, 0, 0);
      add_item(5, 1, 1);
      drive_items();

      while (random_items < RANDOM_ITEMS) begin
         if (random_items > RANDOM_ITEMS - 150) quiet = 1'b1;
         if ($urandom_range(0, 2) == 0) write_k(pick_k());
         if (!pressure_done && random_items > 300) begin
            // receiver holds off while short streams keep coming
            long_hold = 1'b1;
            for (int s = 0; s < 30; s++) add_stream($urandom_range(1, 2));
            random_items += logit_queue.size();
            drive_items();
            wait_for_tokens();
            @(negedge clock);
            pressure_done = 1'b1;
         end else begin
            streams = $urandom_range(1, 4);
            for (int s = 0; s < streams; s++) begin
               add_stream(($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                       : $urandom_range(1, 40));
            end
            random_items += logit_queue.size();
            drive_items();
            if ($urandom_range(0, 3) == 0) begin
               wait_for_tokens();
               @(negedge clock);
            end
         end
      end

      wait_for_tokens();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
